@@ hdl/chtb_pkg.sv @@
`timescale 1ns / 1ps
// Package for the coalesced hash table builder.
// Holds status codes, register indexes and fixed field widths; no dependencies.
package chtb_pkg;

    localparam int KEY_W    = 32;
    localparam int HASH_W   = 32;
    localparam int OFF_W    = 32;
    localparam int IDX_W    = 10;
    localparam int LINK_O_W = 11;
    localparam int RSIZE_W  = 16;

    localparam logic [OFF_W-1:0] OFFSET_CEIL = 32'hffff_ffff;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DUP  = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CFG_SLOT_MASK    = 2'd0,
        CFG_FIRST_OFFSET = 2'd1,
        CFG_RECORD_SIZE  = 2'd2
    } cfg_index_t;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_READ   = 1'b1;

endpackage

@@ hdl/chtb_ram.sv @@
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies; a read of the address being written returns the old word.
module chtb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/coalesced_hash_table_builder.sv @@
`timescale 1ns / 1ps
// Coalesced hash table builder: one slot memory walked by a sequencer.
// Steps: a read fetches the addressed slot and answers; an insert reads its home slot and stores
// there if empty; otherwise it follows the chain (one memory read per link), scans for a free slot
// (one read per slot) and appends, or relocates a foreign entry; duplicate or full ends the insert.
// Throughput: one word at a time, the next accepted once the result sits in the output register.
// Reset: asynchronous, active low; afterwards a clearing pass over every slot holds s_tready low.
module coalesced_hash_table_builder
    import chtb_pkg::*;
#(
    parameter int MAX_SLOTS = 1024
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [79:0]  s_tdata,   // item_key, key_hash, slot_index, zero fill
    input  logic [0:0]   s_tuser,   // op
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [119:0] m_tdata,   // status, placed_slot, entry_key, entry_hash,
                                    // entry_link, entry_offset, zero fill
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    localparam int AW = $clog2(MAX_SLOTS);
    localparam int LW = AW + 1;
    localparam int EW = KEY_W + HASH_W + LW + OFF_W;
    localparam int CW = (LW > IDX_W) ? LW : IDX_W;
    localparam logic [LW-1:0] LINK_END  = LW'(MAX_SLOTS);
    localparam logic [LW-1:0] LAST_SLOT = LW'(MAX_SLOTS - 1);

    typedef enum logic [10:0] {
        S_CLEAR  = 11'b000_0000_0001,
        S_IDLE   = 11'b000_0000_0010,
        S_READ   = 11'b000_0000_0100,
        S_HOME   = 11'b000_0000_1000,
        S_WALK   = 11'b000_0001_0000,
        S_SCAN   = 11'b000_0010_0000,
        S_MOVE   = 11'b000_0100_0000,
        S_RELINK = 11'b000_1000_0000,
        S_APPEND = 11'b001_0000_0000,
        S_STORE  = 11'b010_0000_0000,
        S_RESP   = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [IDX_W-1:0]   mask_reg, mask_next;
    logic [RSIZE_W-1:0] rsize_reg, rsize_next;
    logic [OFF_W-1:0]   noff_reg, noff_next;
    logic [LW-1:0]      clr_reg, clr_next;
    logic [LW-1:0]      low_reg, low_next;
    logic [LW-1:0]      steps_reg, steps_next;
    logic               stop_reg, stop_next;
    logic               reloc_reg, reloc_next;
    logic               fwd_reg, fwd_next;
    logic               op_reg, op_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [HASH_W-1:0]  hash_reg, hash_next;
    logic [AW-1:0]      home_reg, home_next;
    logic [AW-1:0]      ptr_reg, ptr_next;
    logic [AW-1:0]      free_reg, free_next;
    logic [EW-1:0]      ent_reg, ent_next;
    logic [1:0]         rstat_reg, rstat_next;
    logic [AW-1:0]      rplace_reg, rplace_next;
    logic [EW-1:0]      rent_reg, rent_next;
    logic               out_valid_reg, out_valid_next;
    logic [119:0]       out_data_reg, out_data_next;

    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [EW-1:0] mem_wdata, mem_rdata, cur;

    logic [AW-1:0]     cap;
    logic [CW-1:0]     mask_ext;
    logic [AW-1:0]     s_home;
    logic [IDX_W-1:0]  s_idx;
    logic [OFF_W-1:0]  store_off;
    logic [OFF_W:0]    off_sum;
    logic [LW-1:0]     low_inc;
    logic              walk_eval;

    logic [OFF_W-1:0]  r_off;
    logic [LW-1:0]     r_link;
    logic [HASH_W-1:0] r_hash;
    logic [KEY_W-1:0]  r_key;

    chtb_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_SLOTS)
    ) u_slots (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign mask_ext = CW'(mask_reg);
    assign cap      = (mask_ext > CW'(MAX_SLOTS - 1)) ? AW'(MAX_SLOTS - 1) : AW'(mask_ext);
    assign s_home   = s_tdata[KEY_W +: AW] & cap;
    assign s_idx    = s_tdata[KEY_W + HASH_W +: IDX_W];

    assign cur    = (state_reg == S_RELINK && fwd_reg) ? ent_reg : mem_rdata;
    assign r_off  = cur[0 +: OFF_W];
    assign r_link = cur[OFF_W +: LW];
    assign r_hash = cur[OFF_W + LW +: HASH_W];
    assign r_key  = cur[OFF_W + LW + HASH_W +: KEY_W];

    assign store_off = (noff_reg == '0) ? OFF_W'(1) : noff_reg;
    assign off_sum   = {1'b0, store_off} + (OFF_W + 1)'(rsize_reg);
    assign low_inc   = low_reg + LW'(1);
    assign walk_eval = (state_reg == S_WALK) ||
                       (state_reg == S_HOME && r_off != '0 && ((r_hash[AW-1:0] & cap) == home_reg));

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        mask_next      = mask_reg;
        rsize_next     = rsize_reg;
        noff_next      = noff_reg;
        clr_next       = clr_reg;
        low_next       = low_reg;
        steps_next     = steps_reg;
        stop_next      = stop_reg;
        reloc_next     = reloc_reg;
        fwd_next       = fwd_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        hash_next      = hash_reg;
        home_next      = home_reg;
        ptr_next       = ptr_reg;
        free_next      = free_reg;
        ent_next       = ent_reg;
        rstat_next     = rstat_reg;
        rplace_next    = rplace_reg;
        rent_next      = rent_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        mem_we         = 1'b0;
        mem_waddr      = ptr_reg;
        mem_wdata      = ent_reg;
        mem_raddr      = ptr_reg;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg[AW-1:0];
                mem_wdata = {{KEY_W{1'b0}}, {HASH_W{1'b0}}, LINK_END, {OFF_W{1'b0}}};
                clr_next  = clr_reg + LW'(1);
                if (clr_reg == LAST_SLOT)
                begin
                    low_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next    = s_tuser[0];
                    key_next   = s_tdata[0 +: KEY_W];
                    hash_next  = s_tdata[KEY_W +: HASH_W];
                    rstat_next = ST_OK;
                    rplace_next = '0;
                    rent_next  = {{KEY_W{1'b0}}, {HASH_W{1'b0}}, LINK_END, {OFF_W{1'b0}}};
                    if (s_tuser[0] == OP_READ)
                    begin
                        if (CW'(s_idx) < CW'(MAX_SLOTS))
                        begin
                            mem_raddr  = AW'(s_idx);
                            state_next = S_READ;
                        end
                        else
                        begin
                            state_next = S_RESP;
                        end
                    end
                    else
                    begin
                        mem_raddr  = s_home;
                        home_next  = s_home;
                        ptr_next   = s_home;
                        steps_next = '0;
                        stop_next  = 1'b0;
                        state_next = S_HOME;
                    end
                end
            end
            S_READ:
            begin
                rent_next  = mem_rdata;
                state_next = S_RESP;
            end
            S_HOME, S_WALK:
            begin
                if (state_reg == S_HOME && r_off == '0)
                begin
                    free_next  = home_reg;
                    state_next = S_STORE;
                end
                else if (!walk_eval)
                begin
                    ent_next   = mem_rdata;
                    reloc_next = 1'b1;
                    if (low_reg == LINK_END)
                    begin
                        rstat_next = ST_FULL;
                        state_next = S_RESP;
                    end
                    else
                    begin
                        mem_raddr  = low_reg[AW-1:0];
                        state_next = S_SCAN;
                    end
                end
                else if (!stop_reg && r_key == key_reg)
                begin
                    rstat_next  = ST_DUP;
                    rplace_next = ptr_reg;
                    state_next  = S_RESP;
                end
                else if (stop_reg || r_link >= LINK_END)
                begin
                    ent_next   = mem_rdata;
                    reloc_next = 1'b0;
                    if (low_reg == LINK_END)
                    begin
                        rstat_next = ST_FULL;
                        state_next = S_RESP;
                    end
                    else
                    begin
                        mem_raddr  = low_reg[AW-1:0];
                        state_next = S_SCAN;
                    end
                end
                else
                begin
                    ptr_next   = r_link[AW-1:0];
                    mem_raddr  = r_link[AW-1:0];
                    steps_next = steps_reg + LW'(1);
                    stop_next  = (steps_reg == LAST_SLOT);
                    state_next = S_WALK;
                end
            end
            S_SCAN:
            begin
                if (r_off == '0)
                begin
                    if (low_reg[AW-1:0] > cap)
                    begin
                        rstat_next = ST_FULL;
                        state_next = S_RESP;
                    end
                    else
                    begin
                        free_next  = low_reg[AW-1:0];
                        state_next = reloc_reg ? S_MOVE : S_APPEND;
                    end
                end
                else
                begin
                    low_next = low_inc;
                    if (low_inc == LINK_END)
                    begin
                        rstat_next = ST_FULL;
                        state_next = S_RESP;
                    end
                    else
                    begin
                        mem_raddr = low_inc[AW-1:0];
                    end
                end
            end
            S_MOVE:
            begin
                mem_we     = 1'b1;
                mem_waddr  = free_reg;
                mem_wdata  = ent_reg;
                ptr_next   = ent_reg[OFF_W + LW +: AW] & cap;
                mem_raddr  = ent_reg[OFF_W + LW +: AW] & cap;
                fwd_next   = ((ent_reg[OFF_W + LW +: AW] & cap) == free_reg);
                steps_next = '0;
                state_next = S_RELINK;
            end
            S_RELINK:
            begin
                fwd_next = 1'b0;
                ent_next = cur;
                if (r_link == LW'(home_reg))
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = ptr_reg;
                    mem_wdata  = cur;
                    mem_wdata[OFF_W +: LW] = LW'(free_reg);
                    free_next  = home_reg;
                    state_next = S_STORE;
                end
                else if (r_link >= LINK_END || steps_reg == LAST_SLOT)
                begin
                    free_next  = home_reg;
                    state_next = S_STORE;
                end
                else
                begin
                    ptr_next   = r_link[AW-1:0];
                    mem_raddr  = r_link[AW-1:0];
                    steps_next = steps_reg + LW'(1);
                end
            end
            S_APPEND:
            begin
                mem_we     = 1'b1;
                mem_waddr  = ptr_reg;
                mem_wdata  = ent_reg;
                mem_wdata[OFF_W +: LW] = LW'(free_reg);
                state_next = S_STORE;
            end
            S_STORE:
            begin
                mem_we      = 1'b1;
                mem_waddr   = free_reg;
                mem_wdata   = {key_reg, hash_reg, LINK_END, store_off};
                noff_next   = off_sum[OFF_W] ? OFFSET_CEIL : off_sum[OFF_W-1:0];
                rstat_next  = ST_OK;
                rplace_next = free_reg;
                state_next  = S_RESP;
            end
            S_RESP:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    if (op_reg == OP_READ)
                    begin
                        out_data_next = {1'b0,
                                         rent_reg[0 +: OFF_W],
                                         LINK_O_W'(rent_reg[OFF_W +: LW]),
                                         rent_reg[OFF_W + LW +: HASH_W],
                                         rent_reg[OFF_W + LW + HASH_W +: KEY_W],
                                         {IDX_W{1'b0}}, 2'b00};
                    end
                    else
                    begin
                        out_data_next = {1'b0, {OFF_W{1'b0}}, {LINK_O_W{1'b0}},
                                         {HASH_W{1'b0}}, {KEY_W{1'b0}},
                                         IDX_W'(rplace_reg), rstat_reg};
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_SLOT_MASK:    mask_next  = cfg_data[IDX_W-1:0];
                CFG_FIRST_OFFSET: noff_next  = cfg_data;
                CFG_RECORD_SIZE:  rsize_next = cfg_data[RSIZE_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            mask_reg      <= '1;
            rsize_reg     <= RSIZE_W'(1);
            noff_reg      <= OFF_W'(1);
            clr_reg       <= '0;
            low_reg       <= '0;
            steps_reg     <= '0;
            stop_reg      <= 1'b0;
            reloc_reg     <= 1'b0;
            fwd_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mask_reg      <= mask_next;
            rsize_reg     <= rsize_next;
            noff_reg      <= noff_next;
            clr_reg       <= clr_next;
            low_reg       <= low_next;
            steps_reg     <= steps_next;
            stop_reg      <= stop_next;
            reloc_reg     <= reloc_next;
            fwd_reg       <= fwd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        key_reg      <= key_next;
        hash_reg     <= hash_next;
        home_reg     <= home_next;
        ptr_reg      <= ptr_next;
        free_reg     <= free_next;
        ent_reg      <= ent_next;
        rstat_reg    <= rstat_next;
        rplace_reg   <= rplace_next;
        rent_reg     <= rent_next;
        out_data_reg <= out_data_next;
    end

`ifndef ASSERT_OFF
    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE || state_reg == S_RESP) |-> !mem_we)
        else $error("slot memory written outside an insert");

    a_low_bound: assert property (@(posedge clk) disable iff (!rst_n)
        low_reg <= LINK_END)
        else $error("free-slot scan pointer out of range");

    a_steps_bound: assert property (@(posedge clk) disable iff (!rst_n)
        steps_reg <= LINK_END)
        else $error("chain walk step count out of range");
`endif

endmodule

@@ bench/coalesced_hash_table_builder_tb.sv @@
`timescale 1ns / 1ps
// Testbench for the coalesced hash table builder: streams inserts and slot reads
// through the block and checks every result word against a built-in table model.
// Depends on chtb_pkg and coalesced_hash_table_builder.
module coalesced_hash_table_builder_tb;
    import chtb_pkg::*;

    localparam int NSLOT = 1024;
    localparam int LEND = 1024;
    localparam longint CYCLE_LIMIT = 10000000;

    typedef struct packed {
        logic [31:0] offset;
        logic [10:0] link;
        logic [31:0] hash;
        logic [31:0] key;
        logic [9:0]  placed;
        logic [1:0]  status;
    } table_result_t;

    class table_scoreboard;
        logic [31:0] tkey [NSLOT];
        logic [31:0] thash [NSLOT];
        logic [10:0] tlink [NSLOT];
        logic [31:0] toff [NSLOT];
        logic [9:0]  mask;
        logic [31:0] first_off;
        logic [15:0] rec_size;
        logic [31:0] run_off;
        table_result_t pending[$];
        int errors;

        function void clear();
            for (int i = 0; i < NSLOT; i++)
            begin
                tkey[i] = 0;
                thash[i] = 0;
                tlink[i] = 11'(LEND);
                toff[i] = 0;
            end
            mask = 10'h3ff;
            first_off = 1;
            rec_size = 16'd1;
            run_off = 1;
            errors = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] val);
            if (idx == CFG_SLOT_MASK)
                mask = val[9:0];
            else if (idx == CFG_FIRST_OFFSET)
            begin
                first_off = val;
                run_off = val;
            end
            else if (idx == CFG_RECORD_SIZE)
                rec_size = val[15:0];
        endfunction

        function bit find_free(output int slot);
            for (int i = 0; i <= mask; i++)
            begin
                if (toff[i] == 0)
                begin
                    slot = i;
                    return 1;
                end
            end
            return 0;
        endfunction

        function void store(int s, logic [31:0] k, logic [31:0] h);
            logic [32:0] sum;
            tkey[s] = k;
            thash[s] = h;
            tlink[s] = 11'(LEND);
            toff[s] = (run_off != 0) ? run_off : 32'd1;
            sum = {1'b0, toff[s]} + rec_size;
            run_off = sum[32] ? OFFSET_CEIL : sum[31:0];
        endfunction

        function void insert_key(logic [31:0] k, logic [31:0] h, output table_result_t r);
            int home, owner, fr, p, nxt;
            r = '0;
            home = h & mask;
            if (toff[home] == 0)
            begin
                store(home, k, h);
                r.placed = 10'(home);
                return;
            end
            owner = thash[home] & mask;
            if (owner != home)
            begin
                if (!find_free(fr))
                begin
                    r.status = ST_FULL;
                    return;
                end
                tkey[fr] = tkey[home];
                thash[fr] = thash[home];
                tlink[fr] = tlink[home];
                toff[fr] = toff[home];
                p = owner;
                for (int st = 0; st < NSLOT; st++)
                begin
                    nxt = tlink[p];
                    if (nxt == home)
                    begin
                        tlink[p] = 11'(fr);
                        break;
                    end
                    if (nxt >= NSLOT)
                        break;
                    p = nxt;
                end
                store(home, k, h);
                r.placed = 10'(home);
                return;
            end
            p = home;
            for (int st = 0; st < NSLOT; st++)
            begin
                if (tkey[p] == k)
                begin
                    r.status = ST_DUP;
                    r.placed = 10'(p);
                    return;
                end
                nxt = tlink[p];
                if (nxt >= NSLOT)
                    break;
                p = nxt;
            end
            if (!find_free(fr))
            begin
                r.status = ST_FULL;
                return;
            end
            tlink[p] = 11'(fr);
            store(fr, k, h);
            r.placed = 10'(fr);
        endfunction

        function void note_word(logic op, logic [31:0] k, logic [31:0] h, logic [9:0] idx);
            table_result_t r;
            if (op == OP_INSERT)
                insert_key(k, h, r);
            else
            begin
                r = '0;
                r.key = tkey[idx];
                r.hash = thash[idx];
                r.link = tlink[idx];
                r.offset = toff[idx];
            end
            pending.push_back(r);
        endfunction

        function void check_word(table_result_t got);
            table_result_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.status != e.status)
                $display("%0t: status expected %0d actual %0d", $time, e.status, got.status);
            if (got.placed != e.placed)
                $display("%0t: placed_slot expected %0d actual %0d", $time, e.placed, got.placed);
            if (got.key != e.key)
                $display("%0t: entry_key expected %h actual %h", $time, e.key, got.key);
            if (got.hash != e.hash)
                $display("%0t: entry_hash expected %h actual %h", $time, e.hash, got.hash);
            if (got.link != e.link)
                $display("%0t: entry_link expected %0d actual %0d", $time, e.link, got.link);
            if (got.offset != e.offset)
                $display("%0t: entry_offset expected %h actual %h", $time, e.offset, got.offset);
            if (got != e)
                errors++;
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [79:0] s_tdata = '0;
    logic [0:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [119:0] m_tdata;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    table_scoreboard board;
    int send_idle = 0;
    int recv_idle = 0;
    longint cycles = 0;
    logic [31:0] recent_keys [$];

    coalesced_hash_table_builder uut (.*);

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL coalesced_hash_table_builder");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
            board.check_word(table_result_t'(m_tdata[118:0]));
        if (rst_n)
            m_tready <= ($urandom_range(99) >= recv_idle);
    end

    task automatic send_word(logic op, logic [31:0] k, logic [31:0] h, logic [9:0] idx);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 0;
            @(posedge clk);
        end
        s_tvalid <= 1;
        s_tuser <= op;
        s_tdata <= {6'b0, idx, h, k};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        board.note_word(op, k, h, idx);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.set_reg(idx, val);
        cfg_valid <= 0;
        @(posedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (4200)
            @(posedge clk);
    endtask

    task automatic insert_random(int hash_bits);
        logic [31:0] k, h;
        k = $urandom;
        if (recent_keys.size() != 0 && $urandom_range(9) < 2)
            k = recent_keys[$urandom_range(recent_keys.size() - 1)];
        h = $urandom;
        if ($urandom_range(9) < 8)
            h = (h & ~32'h3ff) | $urandom_range((1 << hash_bits) - 1);
        recent_keys.push_back(k);
        if (recent_keys.size() > 32)
            void'(recent_keys.pop_front());
        send_word(OP_INSERT, k, h, 10'($urandom));
    endtask

    task automatic random_phase(int count, int hash_bits);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(3) == 0)
                send_word(OP_READ, $urandom, $urandom, 10'($urandom_range(board.mask)));
            else
                insert_random(hash_bits);
        end
    endtask

    initial
    begin
        board = new();
        board.clear();
        repeat (10)
            @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        send_idle = 19;
        recv_idle = 77;
        send_word(OP_INSERT, 32'h0, 32'h0, 10'h0);
        send_word(OP_INSERT, 32'hffffffff, 32'hffffffff, 10'h3ff);
        send_word(OP_INSERT, 32'h0, 32'h400, 10'h0);
        send_word(OP_INSERT, 32'h12345678, 32'h0, 10'h0);
        send_word(OP_INSERT, 32'h87654321, 32'h1, 10'h0);
        send_word(OP_INSERT, 32'h55aa55aa, 32'h3ff, 10'h0);
        send_word(OP_READ, 32'hffffffff, 32'hffffffff, 10'h0);
        send_word(OP_READ, 32'h0, 32'h0, 10'h1);
        send_word(OP_READ, 32'h0, 32'h0, 10'h3ff);
        send_word(OP_READ, 32'h0, 32'h0, 10'h200);
        drain();

        write_reg(CFG_SLOT_MASK, 32'h3);
        write_reg(CFG_FIRST_OFFSET, 32'hfffffff0);
        write_reg(CFG_RECORD_SIZE, 32'hffff);
        for (int i = 0; i < 8; i++)
            send_word(OP_INSERT, 32'h1000 + i, i, 10'h0);
        for (int i = 0; i < 4; i++)
            send_word(OP_READ, 0, 0, 10'(i));
        drain();

        write_reg(CFG_FIRST_OFFSET, 32'h0);
        write_reg(CFG_RECORD_SIZE, 32'h0);
        write_reg(CFG_SLOT_MASK, 32'h7);
        for (int i = 0; i < 6; i++)
            send_word(OP_INSERT, 32'h2000 + i, 32'h7, 10'h0);
        drain();

        write_reg(CFG_SLOT_MASK, 32'h3f);
        write_reg(CFG_RECORD_SIZE, 32'h10);
        write_reg(CFG_FIRST_OFFSET, 32'h100);
        random_phase(300, 6);
        drain();

        send_idle = 77;
        recv_idle = 19;
        write_reg(CFG_SLOT_MASK, 32'h1f);
        write_reg(CFG_RECORD_SIZE, 32'h1);
        random_phase(300, 5);
        drain();

        send_idle = 0;
        recv_idle = 0;
        write_reg(CFG_SLOT_MASK, 32'h3ff);
        write_reg(CFG_FIRST_OFFSET, $urandom | 1);
        write_reg(CFG_RECORD_SIZE, $urandom_range(65535, 1));
        random_phase(450, 8);
        drain();

        if (board.errors == 0 && board.pending.size() == 0)
            $display("PASS coalesced_hash_table_builder");
        else
            $display("FAIL coalesced_hash_table_builder");
        $finish;
    end
endmodule
